@@ hw/rtl/swm_pkg.sv @@
// Shared constants, types and helpers of the sliding window maximum block.
package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_W        = 7;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int EXT_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int GROUP_SIZE   = 8;
    localparam int NUM_GROUPS   = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CELL_PAD     = NUM_GROUPS * GROUP_SIZE;
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int ADDR_W       = 2;
    localparam int PDATA_W      = 32;

    localparam logic [CFG_W-1:0]  WINDOW_RESET     = CFG_W'(3);
    localparam logic [ADDR_W-1:0] ADDR_WINDOW_SIZE = ADDR_W'(0);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // Broadcast to every cell of the chain but the newest, which gets its own copy with start held low.
    typedef struct packed {
        logic    shift_en;
        logic    start;
        sample_t sample;
    } cell_ctrl_t;

    // Zero acts as one, anything above the cell count acts as the cell count.
    function automatic logic [CNT_W-1:0] effective_window(logic [CFG_W-1:0] ws);
        logic [EXT_W-1:0] ws_ext;
        logic [CNT_W-1:0] k;
        ws_ext = EXT_W'(ws);
        if (ws_ext == '0) begin
            k = CNT_W'(1);
        end else if (ws_ext > EXT_W'(WINDOW_MAX)) begin
            k = CNT_W'(WINDOW_MAX);
        end else begin
            k = CNT_W'(ws_ext);
        end
        return k;
    endfunction

endpackage

@@ hw/rtl/swm_cell.sv @@
// One cell of the queue chain: holds one sample and its membership flag.
module swm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  logic                in_window,
    input  swm_pkg::sample_t    prev_value,
    input  logic                prev_valid,
    output swm_pkg::sample_t    value,
    output logic                valid
);
    import swm_pkg::*;

    sample_t value_reg;
    logic    valid_reg;
    logic    valid_next;

    // An entry survives the shift only if it is still inside the window and
    // is not strictly smaller than the arriving sample.
    always_comb begin
        valid_next = prev_valid && in_window && !(prev_value < ctrl.sample) && !ctrl.start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift_en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            value_reg <= prev_value;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

@@ hw/rtl/swm_head_search.sv @@
// Registered two-level search for the oldest valid cell, which holds the maximum.
module swm_head_search (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             capture,
    input  swm_pkg::sample_t cell_value [swm_pkg::WINDOW_MAX],
    input  logic             cell_valid [swm_pkg::WINDOW_MAX],
    output swm_pkg::sample_t head_value,
    output logic             head_found
);
    import swm_pkg::*;

    sample_t pad_value [CELL_PAD];
    logic    pad_valid [CELL_PAD];

    sample_t grp_value_next [NUM_GROUPS];
    logic    grp_found_next [NUM_GROUPS];
    sample_t grp_value_reg  [NUM_GROUPS];
    logic    grp_found_reg  [NUM_GROUPS];

    for (genvar i = 0; i < CELL_PAD; i++) begin : g_pad
        if (i < WINDOW_MAX) begin : g_real
            assign pad_value[i] = cell_value[i];
            assign pad_valid[i] = cell_valid[i];
        end else begin : g_empty
            assign pad_value[i] = '0;
            assign pad_valid[i] = 1'b0;
        end
    end

    // Within a group the highest valid index wins.
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
        always_comb begin
            grp_value_next[g] = '0;
            grp_found_next[g] = 1'b0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (pad_valid[g * GROUP_SIZE + j]) begin
                    grp_value_next[g] = pad_value[g * GROUP_SIZE + j];
                    grp_found_next[g] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                grp_found_reg[g] <= 1'b0;
            end else if (capture) begin
                grp_found_reg[g] <= grp_found_next[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (capture) begin
                grp_value_reg[g] <= grp_value_next[g];
            end
        end
    end

    always_comb begin
        head_value = '0;
        head_found = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (grp_found_reg[g]) begin
                head_value = grp_value_reg[g];
                head_found = 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/sliding_window_maximum.sv @@
// Sliding window maximum: each sample enters a chain of cells, cell i holding
// the sample that arrived i items ago; a cell stays in the queue only while
// it is inside the window and no later sample is strictly larger, so the
// oldest valid cell holds the maximum of the last window_size samples. A
// sample that produces a result updates the cell chain in its accepting cycle,
// and the next cycle registers the per-group head search while the input is
// held off, so no further sample is taken until that search is captured;
// samples that produce no result can follow back to back. The result moves
// from the search registers into the output register. One result can
// wait behind the output register; when both are full and m_tready is low, the
// input is held off as well. No result is produced until window_size samples
// have arrived since start_req or reset. window_size is written over APB at
// address 0; 0 acts as 1 and values above 64 act as 64.
module sliding_window_maximum (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swm_pkg::TDATA_W-1:0]       s_tdata,   // [15:0] sample
    input  logic                              s_tuser,   // [0] start_req
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swm_pkg::TDATA_W-1:0]       m_tdata,   // [15:0] window_max
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]        paddr,
    input  logic [swm_pkg::PDATA_W-1:0]       pwdata,
    output logic [swm_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import swm_pkg::*;

    logic             s_acc;
    logic             cfg_wr;
    logic [CFG_W-1:0] window_size_reg;
    logic [CNT_W-1:0] win_k;
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;
    logic             emit;
    logic             load_reg;
    logic             pend_reg;
    logic             pend_next;
    logic             pend_move;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    sample_t          out_value_reg;
    sample_t          sample_in;
    sample_t          head_value;
    logic             head_found;
    cell_ctrl_t       ctrl;
    cell_ctrl_t       ctrl_first;
    sample_t          cell_value [WINDOW_MAX];
    logic             cell_valid [WINDOW_MAX];

    // Configuration.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_RESET;
        end else if (cfg_wr) begin
            window_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_WINDOW_SIZE) begin
            prdata = PDATA_W'(window_size_reg);
        end
    end

    assign win_k = effective_window(window_size_reg);

    // Input side.
    assign sample_in = s_tdata[SAMPLE_WIDTH-1:0];
    assign s_acc     = s_tvalid && s_tready;
    assign pend_move = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !load_reg && (!pend_reg || !m_tvalid_reg || m_tready);

    always_comb begin
        if (s_tuser) begin
            seen_next = CNT_W'(1);
        end else if (seen_reg == CNT_W'(WINDOW_MAX)) begin
            seen_next = seen_reg;
        end else begin
            seen_next = seen_reg + CNT_W'(1);
        end
        emit = (seen_next >= win_k);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            load_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                seen_reg <= seen_next;
            end
            load_reg <= s_acc && emit;
        end
    end

    // Cell chain.
    assign ctrl.shift_en = s_acc;
    assign ctrl.start    = s_tuser;
    assign ctrl.sample   = sample_in;

    // The newest cell always takes the sample, even on a start.
    assign ctrl_first.shift_en = s_acc;
    assign ctrl_first.start    = 1'b0;
    assign ctrl_first.sample   = sample_in;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        if (i == 0) begin : g_first
            swm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl_first),
                .in_window  (1'b1),
                .prev_value (sample_in),
                .prev_valid (1'b1),
                .value      (cell_value[i]),
                .valid      (cell_valid[i])
            );
        end else begin : g_rest
            swm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .in_window  (CNT_W'(i) < win_k),
                .prev_value (cell_value[i-1]),
                .prev_valid (cell_valid[i-1]),
                .value      (cell_value[i]),
                .valid      (cell_valid[i])
            );
        end
    end

    swm_head_search u_head (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capture    (load_reg),
        .cell_value (cell_value),
        .cell_valid (cell_valid),
        .head_value (head_value),
        .head_found (head_found)
    );

    // Output side.
    always_comb begin
        pend_next = pend_reg;
        if (load_reg) begin
            pend_next = 1'b1;
        end else if (pend_move) begin
            pend_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (pend_move) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_value_reg <= head_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'($unsigned(out_value_reg));

    // The queue is never empty when a result is due.
    a_head_found: assert property (@(posedge aclk) disable iff (!aresetn)
        load_reg |=> head_found)
        else $error("head search found no valid cell for a result");

    // A new search must never overwrite a result that has not moved out.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_reg |-> !pend_reg)
        else $error("head search captured while a result was pending");

    // An accepted sample always lands in the newest cell.
    a_newest_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (cell_valid[0] && (cell_value[0] == $past(sample_in))))
        else $error("accepted sample missing from the newest cell");

    // The output only turns valid from a pending result.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pend_reg))
        else $error("result transaction without a pending result");

endmodule

@@ tb/sv/tb_sliding_window_maximum.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the sliding window maximum block with its own predictor.
module tb_sliding_window_maximum;
    import swm_pkg::*;

    // Tracks the window maximum from accepted samples and checks each result.
    class window_max_board;
        typedef struct {
            sample_t     value;
            int unsigned pos;
        } held_t;

        held_t            held[$];
        int unsigned      next_pos;
        int unsigned      seen;
        logic [CFG_W-1:0] win_reg;
        sample_t          pending_max[$];
        int               errors;

        function new();
            next_pos = 0;
            seen     = 0;
            win_reg  = WINDOW_RESET;
            errors   = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] w);
            win_reg = w;
        endfunction

        function int unsigned window_span();
            if (win_reg == '0) begin
                return 1;
            end
            if (win_reg > WINDOW_MAX) begin
                return WINDOW_MAX;
            end
            return win_reg;
        endfunction

        function void note_input(sample_t smp, bit first);
            int unsigned k;
            k = window_span();
            if (first) begin
                held.delete();
                seen = 0;
            end
            // Entries that fell out of the window go first, then every
            // strictly smaller entry at the tail; equal values stay.
            while (held.size() > 0 && (next_pos - held[0].pos) >= k) begin
                held.delete(0);
            end
            while (held.size() > 0 && held[held.size() - 1].value < smp) begin
                held.delete(held.size() - 1);
            end
            held.insert(held.size(), held_t'{smp, next_pos});
            next_pos++;
            if (seen < WINDOW_MAX) begin
                seen++;
            end
            if (seen >= k) begin
                pending_max.insert(pending_max.size(), held[0].value);
            end
        endfunction

        function void check_result(logic [SAMPLE_WIDTH-1:0] got);
            sample_t want;
            if (pending_max.size() == 0) begin
                $display("%0t: window_max %0d arrived with nothing expected",
                         $time, sample_t'(got));
                errors++;
                return;
            end
            want = pending_max[0];
            pending_max.delete(0);
            if (want !== sample_t'(got)) begin
                $display("%0t: window_max expected %0d, got %0d",
                         $time, want, sample_t'(got));
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;   // [15:0] sample
    logic                s_tuser;   // [0] start_req
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;   // [15:0] window_max
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    window_max_board board;
    bit              idle_on = 1'b1;
    int              hold_cycles = 0;
    int              quiet_cycles = 0;

    sliding_window_maximum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic send_item(input sample_t smp, input bit first);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(smp);
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        board.note_input(smp, first);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        logic [PDATA_W-1:0] word;
        // Upper bits carry noise; the register keeps only its own width.
        word = $urandom;
        word[CFG_W-1:0] = w;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_SIZE;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_window(w);
    endtask

    // Samples with no result may still be in flight, so a short pause follows.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_max.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2) begin
            case ($urandom_range(0, 3))
                0: return sample_t'(16'h7FFF);
                1: return sample_t'(16'h8000);
                2: return sample_t'(16'h0000);
                default: return sample_t'(16'hFFFF);
            endcase
        end
        if (r < 6) begin
            // A narrow range makes equal values and ties common.
            return sample_t'(int'($urandom_range(0, 8)) - 4);
        end
        return sample_t'($urandom);
    endfunction

    task automatic run_random(input int n_items);
        int left;
        int seq_len;
        int k;
        bit first;
        left = n_items;
        k = board.window_span();
        while (left > 0) begin
            seq_len = $urandom_range(1, 2 * k + 8);
            for (int i = 0; i < seq_len && left > 0; i++) begin
                if (i == 0) begin
                    first = ($urandom_range(0, 9) != 0);
                end else begin
                    first = ($urandom_range(0, 39) == 0);
                end
                send_item(pick_sample(), first);
                left--;
            end
        end
    endtask

    // Result side, with its own random stalls and the one long hold-off.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = idle_on ? $urandom_range(0, 16) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata[SAMPLE_WIDTH-1:0]);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= 2000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] w;
        board = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window of three; the first sequence opens without a start flag.
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        settle();

        // The window grows mid-sequence; dropped samples stay dropped.
        write_window(CFG_W'(5));
        send_item(16'h0005, 1'b0);
        send_item(16'h0003, 1'b0);
        send_item(16'h0002, 1'b0);
        send_item(16'h0001, 1'b0);
        settle();

        // The window shrinks mid-sequence.
        write_window(CFG_W'(2));
        send_item(16'h0004, 1'b0);
        send_item(16'hFFFE, 1'b0);
        send_item(16'hFFFD, 1'b0);
        settle();

        // A window of zero acts as one.
        write_window(CFG_W'(0));
        send_item(16'h8000, 1'b1);
        send_item(16'h7FFF, 1'b0);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: w = CFG_W'(1);
                1: w = CFG_W'(64);
                2: w = CFG_W'(127);
                3: w = CFG_W'(2);
                4: w = CFG_W'($urandom_range(3, 16));
                5: w = CFG_W'($urandom_range(17, 63));
                6: w = CFG_W'($urandom_range(65, 126));
                7: w = CFG_W'(0);
                8: w = CFG_W'($urandom_range(1, 8));
                default: w = CFG_W'(64);
            endcase
            write_window(w);
            idle_on = !(ph == 2 || ph == 7);
            if (ph == 3) begin
                hold_cycles = 300;
            end
            run_random(145);
            settle();
        end

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
